// ===== hdl/escape_time_fractal_iterator_assert.svh =====
// assertion macros for the escape time fractal iterator
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ETI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("eti property violated");
`define ETI_CHECK(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("eti invariant violated");
`else
`define ETI_ASSERT(lbl, prop)
`define ETI_CHECK(lbl, expr)
`endif
`endif

// ===== hdl/eti_pkg.sv =====
// ----------------------------------------------------------------------------
// eti_pkg
// shared types and codes of the escape time fractal iterator
// ----------------------------------------------------------------------------
package eti_pkg;

    localparam int CNT_W = 16;
    localparam int TAG_W = 2;

    localparam logic [2:0] VAR_MANDELBROT = 3'd0;
    localparam logic [2:0] VAR_TRICORN    = 3'd1;
    localparam logic [2:0] VAR_JULIA      = 3'd2;
    localparam logic [2:0] VAR_BURNING    = 3'd3;
    localparam logic [2:0] VAR_CELTIC     = 3'd4;
    localparam logic [2:0] VAR_BUFFALO    = 3'd5;

    localparam logic [1:0] REG_VARIANT  = 2'd0;
    localparam logic [1:0] REG_LIMIT    = 2'd1;
    localparam logic [1:0] REG_JULIA_RE = 2'd2;
    localparam logic [1:0] REG_JULIA_IM = 2'd3;

    typedef struct packed {
        logic             valid;
        logic             done;
        logic             stop;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } slot_ctrl_t;

endpackage

// ===== hdl/escape_time_fractal_iterator.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// escape-time iteration count of one complex point per beat
// ----------------------------------------------------------------------------
// Up to three points are in flight at once, each occupying one slot of a
// three-stage iteration loop (range check and products, escape test and
// variant folding, update). Each slot carries its point round the loop once
// per iteration until it escapes or reaches the limit; a finished point
// keeps circling until it is at the head and the output register can take
// it. Results leave in input order from an output register.
module escape_time_fractal_iterator #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_re,
    input  logic signed [COORD_WIDTH-1:0] point_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   iteration_count,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [((COORD_WIDTH > 16) ? COORD_WIDTH : 16)-1:0] cfg_data
);

    `include "escape_time_fractal_iterator_assert.svh"

    localparam int IW    = FRAC_BITS + 7;
    localparam int MW    = FRAC_BITS + 2;
    localparam int EW    = ((COORD_WIDTH > IW) ? COORD_WIDTH : IW) + 1;
    localparam logic signed [EW-1:0] LIM = EW'(16) <<< FRAC_BITS;

    logic [2:0]                    variant_reg;
    logic [15:0]                   limit_reg;
    logic signed [COORD_WIDTH-1:0] jre_reg;
    logic signed [COORD_WIDTH-1:0] jim_reg;

    eti_pkg::slot_ctrl_t           a_ctrl_reg;
    eti_pkg::slot_ctrl_t           a_ctrl_next;
    logic signed [IW-1:0]          ax_reg, ay_reg, acr_reg, aci_reg;
    logic signed [IW-1:0]          ax_next, ay_next, acr_next, aci_next;

    eti_pkg::slot_ctrl_t           b_ctrl;
    logic signed [2*MW-1:0]        b_xx, b_yy, b_xy;
    logic signed [IW-1:0]          b_cr, b_ci;

    eti_pkg::slot_ctrl_t           c_ctrl;
    logic signed [IW-1:0]          c_re, c_cr, c_ci;
    logic signed [2*MW-1:0]        c_pq;

    logic [eti_pkg::TAG_W-1:0]     head_reg, tail_reg;
    logic                          out_valid_reg;
    logic [15:0]                   count_reg;

    logic                          fin, retire, slot_free;
    logic [2:0]                    var_eff;
    logic [2:0]                    slot_valid;
    logic signed [2*MW-1:0]        ysh;
    logic signed [IW-1:0]          pr_c, pi_c, jr_c, ji_c;

    function automatic logic signed [IW-1:0] clamp_in(input logic signed [COORD_WIDTH-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > LIM)
        begin
            e = LIM;
        end
        if (e < -LIM)
        begin
            e = -LIM;
        end
        return e[IW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= eti_pkg::VAR_MANDELBROT;
            limit_reg   <= 16'd300;
            jre_reg     <= COORD_WIDTH'(-64'sd187904819);
            jim_reg     <= COORD_WIDTH'(64'sd72477573);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eti_pkg::REG_VARIANT:  variant_reg <= cfg_data[2:0];
                eti_pkg::REG_LIMIT:    limit_reg   <= cfg_data[15:0];
                eti_pkg::REG_JULIA_RE: jre_reg     <= cfg_data[COORD_WIDTH-1:0];
                eti_pkg::REG_JULIA_IM: jim_reg     <= cfg_data[COORD_WIDTH-1:0];
                default:               variant_reg <= variant_reg;
            endcase
        end
    end

    assign var_eff = (variant_reg > eti_pkg::VAR_BUFFALO) ? eti_pkg::VAR_MANDELBROT
                                                          : variant_reg;

    eti_square_stage #(.FRAC_BITS(FRAC_BITS), .IW(IW), .MW(MW)) u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (a_ctrl_reg),
        .x        (ax_reg),
        .y        (ay_reg),
        .cr_in    (acr_reg),
        .ci_in    (aci_reg),
        .limit    (limit_reg),
        .ctrl_reg (b_ctrl),
        .xx_reg   (b_xx),
        .yy_reg   (b_yy),
        .xy_reg   (b_xy),
        .cr_reg   (b_cr),
        .ci_reg   (b_ci)
    );

    eti_mix_stage #(.FRAC_BITS(FRAC_BITS), .IW(IW), .MW(MW)) u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .variant  (var_eff),
        .ctrl_in  (b_ctrl),
        .xx_prod  (b_xx),
        .yy_prod  (b_yy),
        .xy_prod  (b_xy),
        .cr_in    (b_cr),
        .ci_in    (b_ci),
        .ctrl_reg (c_ctrl),
        .re_reg   (c_re),
        .pq_reg   (c_pq),
        .cr_reg   (c_cr),
        .ci_reg   (c_ci)
    );

    always_comb
    begin
        fin       = c_ctrl.valid && (c_ctrl.done || c_ctrl.stop);
        retire    = fin && (c_ctrl.tag == head_reg) && (!out_valid_reg || out_ready);
        slot_free = !c_ctrl.valid || retire;
        in_ready  = slot_free;
        ysh       = c_pq >>> (FRAC_BITS - 1);
        pr_c      = clamp_in(point_re);
        pi_c      = clamp_in(point_im);
        jr_c      = clamp_in(jre_reg);
        ji_c      = clamp_in(jim_reg);

        a_ctrl_next = c_ctrl;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        acr_next    = c_cr;
        aci_next    = c_ci;
        if (slot_free)
        begin
            a_ctrl_next.valid = in_valid;
            a_ctrl_next.done  = 1'b0;
            a_ctrl_next.stop  = 1'b0;
            a_ctrl_next.tag   = tail_reg;
            a_ctrl_next.count = '0;
            if (var_eff == eti_pkg::VAR_JULIA)
            begin
                ax_next  = pr_c;
                ay_next  = pi_c;
                acr_next = jr_c;
                aci_next = ji_c;
            end
            else
            begin
                ax_next  = '0;
                ay_next  = '0;
                acr_next = pr_c;
                aci_next = pi_c;
            end
        end
        else if (fin)
        begin
            a_ctrl_next.done = 1'b1;
            a_ctrl_next.stop = 1'b0;
        end
        else
        begin
            a_ctrl_next.count = c_ctrl.count + 16'd1;
            ax_next = c_re + c_cr;
            ay_next = ysh[IW-1:0] + c_ci;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_ctrl_reg <= a_ctrl_next;
            if (slot_free && in_valid)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (retire)
            begin
                head_reg      <= head_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        acr_reg <= acr_next;
        aci_reg <= aci_next;
        if (retire)
        begin
            count_reg <= c_ctrl.count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_reg;
    assign slot_valid      = {a_ctrl_reg.valid, b_ctrl.valid, c_ctrl.valid};

    // slots in the loop match the points between head and tail
    `ETI_CHECK(a_slot_occupancy, (tail_reg - head_reg) == eti_pkg::TAG_W'($countones(slot_valid)))
    // a delivered count never exceeds the limit
    `ETI_ASSERT(a_count_bound, out_valid |-> (iteration_count <= limit_reg))
    // a retired slot leaves the output register full
    `ETI_ASSERT(a_retire_fills, retire |=> out_valid)

endmodule

// ===== hdl/eti_square_stage.sv =====
// ----------------------------------------------------------------------------
// eti_square_stage
// range check and the three products of one iteration, registered
// ----------------------------------------------------------------------------
module eti_square_stage #(
    parameter int FRAC_BITS = 28,
    parameter int IW        = 35,
    parameter int MW        = 30
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  eti_pkg::slot_ctrl_t      ctrl_in,
    input  logic signed [IW-1:0]     x,
    input  logic signed [IW-1:0]     y,
    input  logic signed [IW-1:0]     cr_in,
    input  logic signed [IW-1:0]     ci_in,
    input  logic [eti_pkg::CNT_W-1:0] limit,
    output eti_pkg::slot_ctrl_t      ctrl_reg,
    output logic signed [2*MW-1:0]   xx_reg,
    output logic signed [2*MW-1:0]   yy_reg,
    output logic signed [2*MW-1:0]   xy_reg,
    output logic signed [IW-1:0]     cr_reg,
    output logic signed [IW-1:0]     ci_reg
);

    localparam logic signed [IW-1:0] TWO = IW'(2) <<< FRAC_BITS;

    logic                  big;
    logic signed [MW-1:0]  mx;
    logic signed [MW-1:0]  my;
    eti_pkg::slot_ctrl_t   ctrl_next;

    always_comb
    begin
        big = (x >= TWO) || (x <= -TWO) || (y >= TWO) || (y <= -TWO);
        mx = big ? '0 : x[MW-1:0];
        my = big ? '0 : y[MW-1:0];
        ctrl_next = ctrl_in;
        ctrl_next.stop = big || (ctrl_in.count >= limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg <= mx * mx;
        yy_reg <= my * my;
        xy_reg <= mx * my;
        cr_reg <= cr_in;
        ci_reg <= ci_in;
    end

endmodule

// ===== hdl/eti_mix_stage.sv =====
// ----------------------------------------------------------------------------
// eti_mix_stage
// escape test and variant folding of the real and imaginary terms
// ----------------------------------------------------------------------------
module eti_mix_stage #(
    parameter int FRAC_BITS = 28,
    parameter int IW        = 35,
    parameter int MW        = 30
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2:0]              variant,
    input  eti_pkg::slot_ctrl_t     ctrl_in,
    input  logic signed [2*MW-1:0]  xx_prod,
    input  logic signed [2*MW-1:0]  yy_prod,
    input  logic signed [2*MW-1:0]  xy_prod,
    input  logic signed [IW-1:0]    cr_in,
    input  logic signed [IW-1:0]    ci_in,
    output eti_pkg::slot_ctrl_t     ctrl_reg,
    output logic signed [IW-1:0]    re_reg,
    output logic signed [2*MW-1:0]  pq_reg,
    output logic signed [IW-1:0]    cr_reg,
    output logic signed [IW-1:0]    ci_reg
);

    localparam logic signed [IW-1:0] FOUR = IW'(4) <<< FRAC_BITS;

    logic signed [2*MW-1:0] xxs;
    logic signed [2*MW-1:0] yys;
    logic signed [IW-1:0]   xx;
    logic signed [IW-1:0]   yy;
    logic signed [IW-1:0]   re;
    logic signed [2*MW-1:0] pq;
    logic                   abs_im;
    logic                   abs_re;
    logic                   conj;
    eti_pkg::slot_ctrl_t    ctrl_next;

    always_comb
    begin
        abs_im = (variant == eti_pkg::VAR_BURNING) || (variant == eti_pkg::VAR_BUFFALO);
        abs_re = (variant == eti_pkg::VAR_CELTIC) || (variant == eti_pkg::VAR_BUFFALO);
        conj   = (variant == eti_pkg::VAR_TRICORN);
        xxs = xx_prod >>> FRAC_BITS;
        yys = yy_prod >>> FRAC_BITS;
        xx  = xxs[IW-1:0];
        yy  = yys[IW-1:0];
        re  = xx - yy;
        if (abs_re && re < 0)
        begin
            re = -re;
        end
        pq = xy_prod;
        if (conj || (abs_im && xy_prod < 0))
        begin
            pq = -xy_prod;
        end
        ctrl_next = ctrl_in;
        ctrl_next.stop = ctrl_in.stop || ((xx + yy) >= FOUR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg <= re;
        pq_reg <= pq;
        cr_reg <= cr_in;
        ci_reg <= ci_in;
    end

endmodule
